[src/pida_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_pkg: shared types and constants
// Array depth, field widths, request and status codes, cell operations.
// ----------------------------------------------------------------------------
package pida_pkg;

	localparam int DEPTH   = 64;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DATA_W  = 32;
	localparam int POS_W   = 7;
	localparam int OIDX_W  = 6;
	localparam int FILL_W  = 7;

	typedef enum logic [1:0] {
		REQ_INSERT  = 2'd0,
		REQ_DELETE  = 2'd1,
		REQ_DISPLAY = 2'd2,
		REQ_INVALID = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_BADPOS  = 3'd3,
		ST_INVALID = 3'd4
	} status_t;

	// what a cell loads at the next edge
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_PREV,
		CELL_FROM_NEXT,
		CELL_FROM_HEAD
	} cell_op_t;

endpackage

[src/pida_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_cell: one storage cell of the chain
// Holds one word; takes new data from its neighbors, the head or the load bus.
// ----------------------------------------------------------------------------
module pida_cell (
	input  logic                                clk,
	input  pida_pkg::cell_op_t                  op,
	input  logic signed [pida_pkg::DATA_W-1:0]  load_d,
	input  logic signed [pida_pkg::DATA_W-1:0]  prev_d,
	input  logic signed [pida_pkg::DATA_W-1:0]  next_d,
	input  logic signed [pida_pkg::DATA_W-1:0]  head_d,
	output logic signed [pida_pkg::DATA_W-1:0]  q
);

	logic signed [pida_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			pida_pkg::CELL_LOAD:      data_q <= load_d;
			pida_pkg::CELL_FROM_PREV: data_q <= prev_d;
			pida_pkg::CELL_FROM_NEXT: data_q <= next_d;
			pida_pkg::CELL_FROM_HEAD: data_q <= head_d;
			default:                  data_q <= data_q;
		endcase
	end

	assign q = data_q;

endmodule

[src/positional_insert_delete_array.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_array: ordered word array with positional edits
// Row of cells that shifts up on insert, down on delete, rotates on display.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  --------  --------------------  ---------------------------------------------
//  request   start & !busy         req_type, position, value
//  result    strobe (no stall)     status, element, element_index, fill_count, last
//
//  Insert, delete, invalid and empty-display requests give a single transfer: the
//  status transfer appears the cycle after the request and busy stays low, so
//  such requests may be issued back to back. A display of N entries emits one
//  transfer per cycle, N in all, rotating the row through cell 0; busy is
//  high from the cycle after the request until the last transfer is out.
//  The stored words are not reset; only the count and control flags are.
//  The receiver cannot stall: every transfer is taken in its strobe cycle.
//
module positional_insert_delete_array (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [1:0]                             req_type,
	input  logic [pida_pkg::POS_W-1:0]             position,
	input  logic signed [pida_pkg::DATA_W-1:0]     value,
	output logic                                   strobe,
	output logic [2:0]                             status,
	output logic signed [pida_pkg::DATA_W-1:0]     element,
	output logic [pida_pkg::OIDX_W-1:0]            element_index,
	output logic [pida_pkg::FILL_W-1:0]            fill_count,
	output logic                                   last
);

	// control state
	logic                          disp_q;      // display rotation in progress
	logic [pida_pkg::IDX_W-1:0]    disp_idx_q;  // index of word now in cell 0
	logic [pida_pkg::CNT_W-1:0]    count_q;

	// result register
	logic                                strobe_q;
	pida_pkg::status_t                   status_q;
	logic signed [pida_pkg::DATA_W-1:0]  element_q;
	logic [pida_pkg::OIDX_W-1:0]         element_index_q;
	logic [pida_pkg::FILL_W-1:0]         fill_count_q;
	logic                                last_q;

	// chain
	logic signed [pida_pkg::DATA_W-1:0]  cell_q [pida_pkg::DEPTH];
	pida_pkg::cell_op_t                  cell_op [pida_pkg::DEPTH];

	// request decode
	logic                          accept;
	pida_pkg::req_t                req;
	logic [pida_pkg::POS_W-1:0]    cnt_ext;
	logic                          is_full;
	logic                          is_empty;
	logic                          ins_ok;
	logic                          del_ok;
	logic                          disp_go;
	logic                          disp_last;
	pida_pkg::status_t             single_status;
	logic [pida_pkg::CNT_W-1:0]    next_count;

	assign accept   = start && !disp_q;
	assign req      = pida_pkg::req_t'(req_type);
	assign cnt_ext  = pida_pkg::POS_W'(count_q);
	assign is_full  = (count_q == pida_pkg::CNT_W'(pida_pkg::DEPTH));
	assign is_empty = (count_q == '0);
	assign ins_ok   = accept && (req == pida_pkg::REQ_INSERT) && !is_full
		&& (position <= cnt_ext);
	assign del_ok   = accept && (req == pida_pkg::REQ_DELETE) && !is_empty
		&& (position < cnt_ext);
	assign disp_go  = accept && (req == pida_pkg::REQ_DISPLAY) && !is_empty;

	// final word of a display: the one sitting at index count-1
	assign disp_last = (pida_pkg::CNT_W'(disp_idx_q) + 1'b1) == count_q;

	always_comb begin
		single_status = pida_pkg::ST_OK;
		next_count    = count_q;
		case (req)
			pida_pkg::REQ_INSERT: begin
				if (is_full)
					single_status = pida_pkg::ST_FULL;
				else if (position > cnt_ext)
					single_status = pida_pkg::ST_BADPOS;
				else
					next_count = count_q + 1'b1;
			end
			pida_pkg::REQ_DELETE: begin
				if (is_empty)
					single_status = pida_pkg::ST_EMPTY;
				else if (position >= cnt_ext)
					single_status = pida_pkg::ST_BADPOS;
				else
					next_count = count_q - 1'b1;
			end
			pida_pkg::REQ_DISPLAY: begin
				single_status = pida_pkg::ST_EMPTY;
			end
			default: begin
				single_status = pida_pkg::ST_INVALID;
			end
		endcase
	end

	// Per-cell move select. Insert: cell at position loads the value, cells
	// above it up to count take their lower neighbor. Delete: cells from
	// position up take their upper neighbor. Display: rotate the occupied
	// part left by one, the top occupied cell taking the head word.
	always_comb begin
		for (int i = 0; i < pida_pkg::DEPTH; i++) begin
			cell_op[i] = pida_pkg::CELL_HOLD;
			if (ins_ok) begin
				if (pida_pkg::POS_W'(i) == position)
					cell_op[i] = pida_pkg::CELL_LOAD;
				else if ((pida_pkg::POS_W'(i) > position)
					&& (pida_pkg::POS_W'(i) <= cnt_ext))
					cell_op[i] = pida_pkg::CELL_FROM_PREV;
			end else if (del_ok) begin
				if ((pida_pkg::POS_W'(i) >= position)
					&& (pida_pkg::POS_W'(i + 1) < cnt_ext))
					cell_op[i] = pida_pkg::CELL_FROM_NEXT;
			end else if (disp_q) begin
				if (pida_pkg::POS_W'(i + 1) < cnt_ext)
					cell_op[i] = pida_pkg::CELL_FROM_NEXT;
				else if (pida_pkg::POS_W'(i + 1) == cnt_ext)
					cell_op[i] = pida_pkg::CELL_FROM_HEAD;
			end
		end
	end

	for (genvar g = 0; g < pida_pkg::DEPTH; g++) begin : g_cell
		logic signed [pida_pkg::DATA_W-1:0] prev_w;
		logic signed [pida_pkg::DATA_W-1:0] next_w;

		if (g == 0) begin : g_first
			assign prev_w = value;
		end else begin : g_mid_lo
			assign prev_w = cell_q[g-1];
		end

		if (g == pida_pkg::DEPTH - 1) begin : g_final
			assign next_w = cell_q[0];
		end else begin : g_mid_hi
			assign next_w = cell_q[g+1];
		end

		pida_cell u_cell (
			.clk    (clk),
			.op     (cell_op[g]),
			.load_d (value),
			.prev_d (prev_w),
			.next_d (next_w),
			.head_d (cell_q[0]),
			.q      (cell_q[g])
		);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_q     <= 1'b0;
			disp_idx_q <= '0;
			count_q    <= '0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= accept && !disp_go ? 1'b1 : disp_q;
			if (accept)
				count_q <= next_count;
			if (disp_go) begin
				disp_q     <= 1'b1;
				disp_idx_q <= '0;
			end else if (disp_q) begin
				disp_idx_q <= disp_idx_q + 1'b1;
				if (disp_last)
					disp_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (disp_q) begin
			status_q        <= pida_pkg::ST_OK;
			element_q       <= cell_q[0];
			element_index_q <= pida_pkg::OIDX_W'(disp_idx_q);
			fill_count_q    <= pida_pkg::FILL_W'(count_q);
			last_q          <= disp_last;
		end else begin
			status_q        <= single_status;
			element_q       <= '0;
			element_index_q <= '0;
			fill_count_q    <= pida_pkg::FILL_W'(next_count);
			last_q          <= 1'b1;
		end
	end

	assign busy          = disp_q;
	assign strobe        = strobe_q;
	assign status        = status_q;
	assign element       = element_q;
	assign element_index = element_index_q;
	assign fill_count    = fill_count_q;
	assign last          = last_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pida_pkg::CNT_W'(pida_pkg::DEPTH))
		else $error("count above depth");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !disp_go) |=> (strobe_q && last_q && !disp_q))
		else $error("single request gave no final transfer");

	a_display_end: assert property (@(posedge clk) disable iff (!arst_n)
		(disp_q && disp_last) |=> (strobe_q && last_q && !disp_q))
		else $error("display did not end on its last word");

	a_count_still: assert property (@(posedge clk) disable iff (!arst_n)
		disp_q |=> $stable(count_q))
		else $error("count moved during display");
`endif

endmodule
